[hdl/qpc_pkg.sv]
`default_nettype none

package qpc_pkg;

    localparam int NEW_POS_WIDTH = 16;
    localparam int LIMIT_WIDTH   = 8;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int S_TDATA_WIDTH = 24;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_MIN_POSITION = 2'd0,
        REG_MAX_POSITION = 2'd1,
        REG_WRAP_ENABLE  = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef logic signed [1:0] step_t;

    // indexed by {previous pins, current pins}, pins are {b, a}
    localparam step_t STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    localparam logic [1:0] PINS_IDLE = 2'b11;

    typedef struct packed {
        op_t                              op;
        logic [1:0]                       pins;
        logic signed [NEW_POS_WIDTH-1:0]  new_position;
    } item_t;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] min_position;
        logic [LIMIT_WIDTH-1:0] max_position;
        logic                   wrap_enable;
    } limits_t;

endpackage

`default_nettype wire

[hdl/qpc_in_stage.sv]
`default_nettype none

module qpc_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire qpc_pkg::item_t in_item,
    input  wire logic           advance,
    output logic                item_valid,
    output qpc_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    qpc_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hdl/qpc_tracker.sv]
`default_nettype none

module qpc_tracker #(
    parameter int POSITION_WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire qpc_pkg::item_t   item,
    input  wire qpc_pkg::limits_t limits,
    output logic [POSITION_WIDTH-1:0] position,
    output logic                  changed
);

    localparam int FINE_WIDTH = POSITION_WIDTH + 2;

    logic [1:0]            last_pins_reg;
    logic [1:0]            last_pins_next;
    logic [FINE_WIDTH-1:0] fine_count_reg;
    logic [FINE_WIDTH-1:0] fine_count_next;

    logic [1:0]                       cur_pins;
    qpc_pkg::step_t                   step;
    logic [FINE_WIDTH-1:0]            fine_stepped;
    logic signed [POSITION_WIDTH:0]   detent_ext;
    logic signed [POSITION_WIDTH:0]   min_ext;
    logic signed [POSITION_WIDTH:0]   max_ext;
    logic [POSITION_WIDTH-1:0]        min_bits;
    logic [POSITION_WIDTH-1:0]        max_bits;
    logic [POSITION_WIDTH-1:0]        load_bits;

    always_comb begin
        cur_pins     = item.pins;
        step         = qpc_pkg::STEP_TABLE[{last_pins_reg, cur_pins}];
        fine_stepped = fine_count_reg + FINE_WIDTH'(step);
        detent_ext   = (POSITION_WIDTH+1)'($signed(fine_stepped[FINE_WIDTH-1:2]));
        min_bits     = POSITION_WIDTH'(limits.min_position);
        max_bits     = POSITION_WIDTH'(limits.max_position);
        min_ext      = $signed({1'b0, min_bits});
        max_ext      = $signed({1'b0, max_bits});
        load_bits    = POSITION_WIDTH'(item.new_position);

        last_pins_next  = last_pins_reg;
        fine_count_next = fine_count_reg;
        changed         = 1'b0;

        if (item.op == qpc_pkg::OP_LOAD) begin
            fine_count_next = {load_bits, fine_count_reg[1:0]};
        end else if (cur_pins != last_pins_reg) begin
            changed        = 1'b1;
            last_pins_next = cur_pins;
            if (detent_ext < min_ext) begin
                fine_count_next = {limits.wrap_enable ? max_bits : min_bits,
                                   fine_stepped[1:0]};
            end else if (detent_ext > max_ext) begin
                fine_count_next = {limits.wrap_enable ? min_bits : max_bits,
                                   fine_stepped[1:0]};
            end else begin
                fine_count_next = fine_stepped;
            end
        end

        position = fine_count_next[FINE_WIDTH-1:2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg  <= qpc_pkg::PINS_IDLE;
            fine_count_reg <= '0;
        end else if (advance) begin
            last_pins_reg  <= last_pins_next;
            fine_count_reg <= fine_count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/quadrature_position_counter_core.sv]
`default_nettype none

// channel   direction  tdata (low bit up)                 tuser
// s_        in         pin_a, pin_b, new_position, pad    operation
// m_        out        position, pad                      changed
// cfg_      in         index 0 min, 1 max, 2 wrap         -
//
// one item per cycle while the result side is not stalled by m_tready
// an input register and a result register, the tracker update sits between them
// a stalled result holds the tracker, the input register still takes one item
// aresetn clears valid flags, pins to idle high, count to zero, limits to 0/255/clamp
// config writes always ready, registered into the limits that the tracker then uses

module quadrature_position_counter_core #(
    parameter int  POSITION_WIDTH = 16,
    localparam int M_TDATA_WIDTH  = ((POSITION_WIDTH + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [qpc_pkg::S_TDATA_WIDTH-1:0]  s_tdata,   // pin_a, pin_b, new_position
    input  wire logic                               s_tuser,   // operation
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [M_TDATA_WIDTH-1:0]                m_tdata,   // position
    output logic                                    m_tuser,   // changed
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [qpc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [qpc_pkg::LIMIT_WIDTH-1:0]    cfg_data
);

    qpc_pkg::item_t   in_item;
    qpc_pkg::item_t   item;
    logic             item_valid;
    logic             advance;
    qpc_pkg::limits_t limits_reg;
    qpc_pkg::limits_t limits_next;

    logic [POSITION_WIDTH-1:0] position;
    logic                      changed;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [POSITION_WIDTH-1:0] m_position_reg;
    logic                      m_changed_reg;

    assign in_item.op           = qpc_pkg::op_t'(s_tuser);
    assign in_item.pins         = {s_tdata[1], s_tdata[0]};
    assign in_item.new_position = $signed(s_tdata[qpc_pkg::NEW_POS_WIDTH+1:2]);

    assign advance = item_valid && (!m_valid_reg || m_tready);

    qpc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    qpc_tracker #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item),
        .limits   (limits_reg),
        .position (position),
        .changed  (changed)
    );

    // config registers
    assign cfg_ready = 1'b1;

    always_comb begin
        limits_next = limits_reg;
        if (cfg_valid) begin
            unique case (qpc_pkg::reg_index_t'(cfg_index))
                qpc_pkg::REG_MIN_POSITION: limits_next.min_position = cfg_data;
                qpc_pkg::REG_MAX_POSITION: limits_next.max_position = cfg_data;
                qpc_pkg::REG_WRAP_ENABLE:  limits_next.wrap_enable  = cfg_data[0];
                default:                   limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.min_position <= '0;
            limits_reg.max_position <= '1;
            limits_reg.wrap_enable  <= 1'b0;
        end else begin
            limits_reg <= limits_next;
        end
    end

    // result register
    assign m_valid_next = advance || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_position_reg <= position;
            m_changed_reg  <= changed;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(m_position_reg);
    assign m_tuser  = m_changed_reg;

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;

    localparam int                 POS_W          = 16;
    localparam int                 PHASES         = 8;
    localparam int                 RAND_PER_PHASE = 182;
    localparam int                 LONG_HOLD      = 300;
    localparam int                 SETTLE_CYCLES  = 4;
    localparam logic [1:0]         REG_UNUSED     = 2'd3;

    // quarter-step delta indexed by {previous pins, current pins}, pins are {b, a}
    localparam int                 QUAD_DELTA [16] = '{
         0, -1,  1,  0,
         1,  0,  0, -1,
        -1,  0,  0,  1,
         0,  1, -1,  0
    };
    localparam logic [1:0]         QUAD_FWD  [4] = '{2'b10, 2'b00, 2'b11, 2'b01};
    localparam logic [1:0]         QUAD_BACK [4] = '{2'b01, 2'b11, 2'b00, 2'b10};

    localparam logic [7:0]         PH_MIN  [PHASES] = '{0, 10, 10, 0, 255, 200, 0, 120};
    localparam logic [7:0]         PH_MAX  [PHASES] = '{255, 14, 14, 0, 255, 100, 255, 135};
    localparam logic               PH_WRAP [PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
    localparam int                 SEND_IDLE [4] = '{0, 76, 0, 30};
    localparam int                 RECV_STALL[4] = '{0, 0, 76, 30};

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    changed;
    } pos_result_t;

    typedef struct packed {
        qpc_pkg::op_t            op;
        logic [1:0]              pins;
        logic signed [15:0]      new_pos;
        logic                    typed;
        logic signed [POS_W-1:0] pos;
        logic                    chg;
    } step_row_t;

    localparam int        N_ROWS = 22;
    localparam step_row_t STEP_ROWS [N_ROWS] = '{
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh7FFF, 1'b1, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b00, 16'sd100,  1'b1, 16'sd100,  1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b01, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b00, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b10, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b10, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b00, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b01, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b00, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b10, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b01, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b01, 16'sh8000, 1'b1, 16'sh8000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b11, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b11, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b10, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b00, 16'sd255,  1'b1, 16'sd255,  1'b0},
        '{qpc_pkg::OP_SAMPLE, 2'b00, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
        '{qpc_pkg::OP_LOAD,   2'b00, 16'shFFFF, 1'b1, 16'shFFFF, 1'b0}
    };

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [qpc_pkg::S_TDATA_WIDTH-1:0]   s_tdata   = '0;
    logic                                s_tuser   = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [POS_W-1:0]                    m_tdata;
    logic                                m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [qpc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index = '0;
    logic [qpc_pkg::LIMIT_WIDTH-1:0]     cfg_data  = '0;

    // tracker copy
    logic [1:0]                trk_pins  = qpc_pkg::PINS_IDLE;
    logic [POS_W+1:0]          trk_fine  = '0;
    logic signed [POS_W-1:0]   trk_pos   = '0;
    logic [7:0]                lim_min   = 8'd0;
    logic [7:0]                lim_max   = 8'd255;
    logic                      lim_wrap  = 1'b0;

    pos_result_t               expected_positions [$];
    int                        send_idle_pct = 0;
    int                        stall_pct     = 0;
    int                        hold_left     = 0;
    int                        walk_dir      = 1;
    int                        n_errors  = 0;
    int                        n_items   = 0;
    int                        n_loads   = 0;
    int                        n_moves   = 0;
    int                        n_checked = 0;
    int                        n_writes  = 0;

    quadrature_position_counter_core #(
        .POSITION_WIDTH (POS_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 40) begin
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        n_errors++;
    endtask

    function automatic void set_detent(input logic [POS_W-1:0] v);
        trk_fine = {v, trk_fine[1:0]};
        trk_pos  = v;
    endfunction

    function automatic void track_item(input qpc_pkg::op_t op, input logic [1:0] pins,
                                       input logic signed [15:0] np,
                                       output pos_result_t res);
        res.changed = 1'b0;
        if (op == qpc_pkg::OP_LOAD) begin
            set_detent(POS_W'(np));
        end else if (pins != trk_pins) begin
            trk_fine = trk_fine + (POS_W+2)'(QUAD_DELTA[{trk_pins, pins}]);
            trk_pins = pins;
            trk_pos  = trk_fine[POS_W+1:2];
            if (int'(trk_pos) < int'(lim_min)) begin
                set_detent(lim_wrap ? POS_W'(lim_max) : POS_W'(lim_min));
            end else if (int'(trk_pos) > int'(lim_max)) begin
                set_detent(lim_wrap ? POS_W'(lim_min) : POS_W'(lim_max));
            end
            res.changed = 1'b1;
        end
        res.position = trk_pos;
    endfunction

    task automatic send_item(input qpc_pkg::op_t op, input logic [1:0] pins,
                             input logic signed [15:0] np, input logic typed,
                             input pos_result_t typed_res);
        pos_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, np, pins};
        do @(posedge aclk); while (!s_tready);
        track_item(op, pins, np, res);
        expected_positions.push_back(typed ? typed_res : res);
        n_items++;
        if (op == qpc_pkg::OP_LOAD) n_loads++;
        if (res.changed) n_moves++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi, input logic wrap,
                              input logic poke_unused);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        int         n;
        idx = '{qpc_pkg::REG_MIN_POSITION, qpc_pkg::REG_MAX_POSITION,
                qpc_pkg::REG_WRAP_ENABLE, REG_UNUSED};
        val = '{lo, hi, {7'($urandom), wrap}, 8'($urandom)};
        n   = poke_unused ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                qpc_pkg::REG_MIN_POSITION: lim_min  = val[i];
                qpc_pkg::REG_MAX_POSITION: lim_max  = val[i];
                qpc_pkg::REG_WRAP_ENABLE:  lim_wrap = val[i][0];
                default: ;
            endcase
            n_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int          roll;
        int          v;
        logic [1:0]  pins;
        logic [15:0] np;
        pos_result_t none;
        none = '0;
        roll = $urandom_range(99);
        pins = trk_pins;
        np   = 16'($urandom);
        if (roll < 8) begin
            pins = 2'($urandom);
            case ($urandom_range(3))
                0: v = int'(lim_min) + int'($urandom_range(8)) - 4;
                1: v = int'(lim_max) + int'($urandom_range(8)) - 4;
                2: v = $urandom_range(1) ? 32767 : -32768;
                default: v = int'($signed(np));
            endcase
            send_item(qpc_pkg::OP_LOAD, pins, 16'(v), 1'b0, none);
        end else begin
            if (roll < 14) begin
                pins = trk_pins;
            end else if (roll < 18) begin
                pins = trk_pins ^ 2'b11;
            end else begin
                if ($urandom_range(99) < 6) walk_dir = -walk_dir;
                pins = (walk_dir > 0) ? QUAD_FWD[trk_pins] : QUAD_BACK[trk_pins];
            end
            send_item(qpc_pkg::OP_SAMPLE, pins, np, 1'b0, none);
        end
    endtask

    // result side, long hold-off counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pos_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_positions.size() == 0) begin
                report_mismatch("unexpected item, position", $signed(m_tdata), 0);
            end else begin
                want = expected_positions.pop_front();
                n_checked++;
                if ($signed(m_tdata) !== want.position)
                    report_mismatch("position", $signed(m_tdata), want.position);
                if (m_tuser !== want.changed)
                    report_mismatch("changed", m_tuser, want.changed);
            end
        end
    end

    initial begin
        pos_result_t typed_res;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int r = 0; r < N_ROWS; r++) begin
            typed_res.position = STEP_ROWS[r].pos;
            typed_res.changed  = STEP_ROWS[r].chg;
            send_item(STEP_ROWS[r].op, STEP_ROWS[r].pins, STEP_ROWS[r].new_pos,
                      STEP_ROWS[r].typed, typed_res);
        end
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            set_limits(PH_MIN[p], PH_MAX[p], PH_WRAP[p], p[0]);
            send_idle_pct = SEND_IDLE[p % 4];
            stall_pct     = RECV_STALL[p % 4];
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (p == 2 && k == 30) hold_left = LONG_HOLD;
                if (p == 5 && k == 90) drain_results();
                random_item();
            end
        end
        drain_results();
        repeat (10) @(posedge aclk);
        if (expected_positions.size() != 0)
            report_mismatch("items never delivered", 0, expected_positions.size());
        $display("%0d items sent (%0d loads, %0d pin changes), %0d results checked",
                 n_items, n_loads, n_moves, n_checked);
        $display("%0d register writes over %0d limit settings, clamp and wrap, idle mixes",
                 n_writes, PHASES);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/qpc_pkg.sv
hdl/qpc_in_stage.sv
hdl/qpc_tracker.sv
hdl/quadrature_position_counter_core.sv
dv/tb.sv
